[src/sdc_pkg.sv]
// Shared types, codes and CRC helper for the SD card command-path controller.
`timescale 1ns / 1ps
package sdc_pkg;

  localparam int unsigned BlockWordsDef = 128;
  localparam int unsigned QueueDepthDef = 4;

  // result kinds
  localparam logic [1:0] ResByte   = 2'd0;
  localparam logic [1:0] ResWord   = 2'd1;
  localparam logic [1:0] ResDiv    = 2'd2;
  localparam logic [1:0] ResFinish = 2'd3;

  // finish status
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StTimeout  = 2'd1;
  localparam logic [1:0] StMismatch = 2'd2;
  localparam logic [1:0] StBusy     = 2'd3;

  // request kinds
  localparam logic [2:0] KindInit  = 3'd0;
  localparam logic [2:0] KindRead  = 3'd1;
  localparam logic [2:0] KindReply = 3'd2;
  localparam logic [2:0] KindData  = 3'd3;
  localparam logic [2:0] KindTick  = 3'd4;

  // config register indexes
  localparam logic [1:0] CfgTimeout = 2'd0;
  localparam logic [1:0] CfgVoltage = 2'd1;
  localparam logic [1:0] CfgInitDiv = 2'd2;
  localparam logic [1:0] CfgRunDiv  = 2'd3;

  // command indexes
  localparam logic [5:0] CmdGoIdle   = 6'd0;
  localparam logic [5:0] CmdAllCid   = 6'd2;
  localparam logic [5:0] CmdSendRca  = 6'd3;
  localparam logic [5:0] CmdBusWidth = 6'd6;
  localparam logic [5:0] CmdSelect   = 6'd7;
  localparam logic [5:0] CmdIfCond   = 6'd8;
  localparam logic [5:0] CmdReadBlk  = 6'd17;
  localparam logic [5:0] CmdOpCond   = 6'd41;
  localparam logic [5:0] CmdAppCmd   = 6'd55;

  localparam logic [7:0] DummyByte = 8'hff;
  localparam logic [6:0] CrcPoly   = 7'h09;

  typedef enum logic [2:0] {
    JobNone,
    JobRefuse,
    JobFinish,
    JobData,
    JobFrame,
    JobInit,
    JobDone
  } job_e;

  typedef struct packed {
    job_e        jtype;
    logic [5:0]  cmd;
    logic [31:0] arg;    // command argument or data word
    logic [7:0]  div;
    logic [1:0]  status;
  } job_t;

  typedef struct packed {
    logic [23:0] timeout_ticks;
    logic [23:0] voltage_window;
    logic [7:0]  init_clock_div;
    logic [7:0]  run_clock_div;
  } cfg_t;

  // CRC7 over one byte, MSB first
  function automatic logic [6:0] crc7_byte(logic [6:0] crc_in, logic [7:0] data);
    logic [6:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if (d[7] ^ c[6]) begin
        c = {c[5:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[5:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[src/sdc_front.sv]
// Front part: takes requests and card events, keeps the protocol state, emits jobs.
`timescale 1ns / 1ps
module sdc_front #(
  parameter int unsigned BlockWords = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdc_pkg::cfg_t      cfg_i,
  input  logic               take_i,
  input  logic [2:0]         kind_i,
  input  logic [31:0]        block_number_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [31:0]        rx_word_i,
  output logic               push_o,
  output sdc_pkg::job_t      job_o
);
  import sdc_pkg::*;

  localparam int unsigned WcW = $clog2(BlockWords + 3);

  localparam logic [3:0] PIdle   = 4'd0;
  localparam logic [3:0] PCmd8   = 4'd1;
  localparam logic [3:0] PApp    = 4'd2;
  localparam logic [3:0] POpcond = 4'd3;
  localparam logic [3:0] PCid    = 4'd4;
  localparam logic [3:0] PRca    = 4'd5;
  localparam logic [3:0] PSelect = 4'd6;
  localparam logic [3:0] PAppW   = 4'd7;
  localparam logic [3:0] PWidth  = 4'd8;
  localparam logic [3:0] PRead   = 4'd9;

  logic [3:0]     phase_q, phase_d;
  logic [4:0]     rc_q, rc_d;
  logic [WcW-1:0] wc_q, wc_d;
  logic [23:0]    wait_q, wait_d;
  logic           v2_q, v2_d;
  logic           hc_q, hc_d;
  logic [15:0]    addr_q, addr_d;
  logic [7:0]     hold_q [4];
  logic           hold_we;
  logic [1:0]     hold_idx;

  logic [8:0]     cmd8_arg;
  logic [4:0]     rc_inc;
  logic [4:0]     need;
  logic [24:0]    wait_inc;
  logic [23:0]    limit;
  logic [WcW-1:0] wc_inc;
  job_t           job;

  assign cmd8_arg = {(cfg_i.voltage_window[23:15] != 9'd0), 8'haa};
  assign rc_inc   = rc_q + 5'd1;
  assign need     = (phase_q == PCid) ? 5'd17 : 5'd6;
  assign wait_inc = {1'b0, wait_q} + 25'd1;
  assign limit    = (cfg_i.timeout_ticks == 24'd0) ? 24'd1 : cfg_i.timeout_ticks;
  assign wc_inc   = wc_q + WcW'(1);

  always_comb begin
    phase_d  = phase_q;
    rc_d     = rc_q;
    wc_d     = wc_q;
    wait_d   = wait_q;
    v2_d     = v2_q;
    hc_d     = hc_q;
    addr_d   = addr_q;
    hold_we  = 1'b0;
    hold_idx = 2'(rc_q - 5'd1);
    job      = '{jtype: JobNone, cmd: '0, arg: '0, div: '0, status: StOk};
    if (take_i) begin
      unique case (kind_i)
        KindInit, KindRead: begin
          if (phase_q != PIdle) begin
            job.jtype  = JobRefuse;
            job.status = StBusy;
          end else if (kind_i == KindInit) begin
            v2_d      = 1'b0;
            job.jtype = JobInit;
            job.div   = cfg_i.init_clock_div;
            job.arg   = {23'd0, cmd8_arg};
            phase_d   = PCmd8;
            rc_d      = '0;
            wait_d    = '0;
          end else begin
            job.jtype = JobFrame;
            job.cmd   = CmdReadBlk;
            job.arg   = hc_q ? block_number_i : {block_number_i[22:0], 9'd0};
            phase_d   = PRead;
            rc_d      = '0;
            wait_d    = '0;
            wc_d      = '0;
          end
        end
        KindReply: begin
          if (phase_q == PRead) begin
            if (rc_q < 5'd6) begin
              rc_d   = rc_inc;
              wait_d = '0;
            end
          end else if (phase_q != PIdle) begin
            hold_we = (rc_q >= 5'd1) && (rc_q <= 5'd4);
            rc_d    = rc_inc;
            wait_d  = '0;
            if (rc_inc >= need) begin
              rc_d      = '0;
              job.jtype = JobFrame;
              unique case (phase_q)
                PCmd8: begin
                  if ({hold_q[2], hold_q[3]} != {7'd0, cmd8_arg}) begin
                    job.jtype  = JobFinish;
                    job.status = StMismatch;
                    phase_d    = PIdle;
                    wc_d       = '0;
                  end else begin
                    v2_d    = 1'b1;
                    job.cmd = CmdAppCmd;
                    phase_d = PApp;
                  end
                end
                PApp: begin
                  job.cmd = CmdOpCond;
                  job.arg = {1'b0, v2_q, 6'd0, cfg_i.voltage_window};
                  phase_d = POpcond;
                end
                POpcond: begin
                  if (hold_q[0][7]) begin
                    hc_d    = hold_q[0][6];
                    job.cmd = CmdAllCid;
                    phase_d = PCid;
                  end else begin
                    job.cmd = CmdAppCmd;
                    phase_d = PApp;
                  end
                end
                PCid: begin
                  job.cmd = CmdSendRca;
                  phase_d = PRca;
                end
                PRca: begin
                  addr_d  = {hold_q[0], hold_q[1]};
                  job.cmd = CmdSelect;
                  job.arg = {hold_q[0], hold_q[1], 16'd0};
                  phase_d = PSelect;
                end
                PSelect: begin
                  job.cmd = CmdAppCmd;
                  job.arg = {addr_q, 16'd0};
                  phase_d = PAppW;
                end
                PAppW: begin
                  job.cmd = CmdBusWidth;
                  job.arg = 32'd2;
                  phase_d = PWidth;
                end
                default: begin
                  job.jtype = JobDone;
                  job.div   = cfg_i.run_clock_div;
                  phase_d   = PIdle;
                  wc_d      = '0;
                end
              endcase
            end
          end
        end
        KindData: begin
          if (phase_q == PRead) begin
            wait_d = '0;
            wc_d   = wc_inc;
            if (wc_q < WcW'(BlockWords)) begin
              job.jtype = JobData;
              job.arg   = rx_word_i;
            end else if (wc_inc >= WcW'(BlockWords + 2)) begin
              job.jtype  = JobFinish;
              job.status = StOk;
              phase_d    = PIdle;
              rc_d       = '0;
              wc_d       = '0;
            end
          end
        end
        KindTick: begin
          if (phase_q != PIdle) begin
            if (wait_inc >= {1'b0, limit}) begin
              wait_d = '0;
              rc_d   = '0;
              if (phase_q == PCmd8) begin
                v2_d      = 1'b0;
                job.jtype = JobFrame;
                job.cmd   = CmdAppCmd;
                phase_d   = PApp;
              end else begin
                job.jtype  = JobFinish;
                job.status = StTimeout;
                phase_d    = PIdle;
                wc_d       = '0;
              end
            end else begin
              wait_d = wait_inc[23:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push_o = job.jtype != JobNone;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PIdle;
      rc_q    <= '0;
      wc_q    <= '0;
      wait_q  <= '0;
      v2_q    <= 1'b0;
      hc_q    <= 1'b0;
      addr_q  <= '0;
    end else begin
      phase_q <= phase_d;
      rc_q    <= rc_d;
      wc_q    <= wc_d;
      wait_q  <= wait_d;
      v2_q    <= v2_d;
      hc_q    <= hc_d;
      addr_q  <= addr_d;
    end
  end

  // reply bytes 1..4, written before read
  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      hold_q[hold_idx] <= rx_byte_i;
    end
  end

endmodule

[src/sdc_fifo.sv]
// Short job queue between front and back.
`timescale 1ns / 1ps
module sdc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sdc_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output sdc_pkg::job_t data_o
);
  import sdc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + PtrW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("job popped from empty queue");

endmodule

[src/sdc_back.sv]
// Back part: jobs to result words, CRC7 on frames, one per cycle unless stalled.
`timescale 1ns / 1ps
module sdc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  sdc_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    kind_res_o,
  output logic [7:0]    out_byte_o,
  output logic [31:0]   out_word_o,
  output logic [7:0]    clock_divisor_o,
  output logic [1:0]    status_o,
  output logic          last_o
);
  import sdc_pkg::*;

  logic [3:0]  step_q;
  logic [6:0]  crc_q;
  logic        load;
  logic        is_end;
  logic [1:0]  r_kind;
  logic [7:0]  r_byte;
  logic [31:0] r_word;
  logic [7:0]  r_div;
  logic [1:0]  r_status;
  logic        in_frame;
  logic [5:0]  f_cmd;
  logic [31:0] f_arg;
  logic [2:0]  fb;
  logic [6:0]  crc_in;
  logic [7:0]  f_byte;

  logic        valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [31:0] word_q;
  logic [7:0]  div_q;
  logic [1:0]  status_q;
  logic        last_q;

  assign load  = job_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load && is_end;

  always_comb begin
    in_frame = 1'b0;
    f_cmd    = job_i.cmd;
    f_arg    = job_i.arg;
    fb       = step_q[2:0];
    r_kind   = ResByte;
    r_byte   = '0;
    r_word   = '0;
    r_div    = '0;
    r_status = StOk;
    is_end   = 1'b0;
    unique case (job_i.jtype)
      JobData: begin
        r_kind = ResWord;
        r_word = job_i.arg;
        is_end = 1'b1;
      end
      JobFrame: begin
        in_frame = 1'b1;
        is_end   = step_q == 4'd5;
      end
      JobInit: begin
        // divisor, CMD0, dummy byte, CMD8
        if (step_q == 4'd0) begin
          r_kind = ResDiv;
          r_div  = job_i.div;
        end else if (step_q <= 4'd6) begin
          in_frame = 1'b1;
          f_cmd    = CmdGoIdle;
          f_arg    = '0;
          fb       = 3'(step_q - 4'd1);
        end else if (step_q == 4'd7) begin
          r_byte = DummyByte;
        end else begin
          in_frame = 1'b1;
          f_cmd    = CmdIfCond;
          fb       = 3'(step_q - 4'd8);
          is_end   = step_q == 4'd13;
        end
      end
      JobDone: begin
        if (step_q == 4'd0) begin
          r_kind = ResDiv;
          r_div  = job_i.div;
        end else begin
          r_kind = ResFinish;
          is_end = 1'b1;
        end
      end
      default: begin
        // refuse and finish jobs
        r_kind   = ResFinish;
        r_status = job_i.status;
        is_end   = 1'b1;
      end
    endcase
  end

  assign crc_in = (fb == 3'd0) ? 7'd0 : crc_q;

  always_comb begin
    unique case (fb)
      3'd0:    f_byte = {2'b01, f_cmd};
      3'd1:    f_byte = f_arg[31:24];
      3'd2:    f_byte = f_arg[23:16];
      3'd3:    f_byte = f_arg[15:8];
      3'd4:    f_byte = f_arg[7:0];
      default: f_byte = {crc_q, 1'b1};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
      crc_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= is_end ? 4'd0 : step_q + 4'd1;
        if (in_frame) begin
          crc_q <= crc7_byte(crc_in, f_byte);
        end
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= r_kind;
      byte_q   <= in_frame ? f_byte : r_byte;
      word_q   <= r_word;
      div_q    <= r_div;
      status_q <= r_status;
      last_q   <= is_end;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_res_o      = kind_q;
  assign out_byte_o      = byte_q;
  assign out_word_o      = word_q;
  assign clock_divisor_o = div_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 4'd13) else $error("sequencer step out of range");
  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q == ResFinish |-> last_q) else $error("finish word not last");

endmodule

[src/sd_card_init_and_block_read_top.sv]
// Top level of the SD card init and single-block read command-path controller.
`timescale 1ns / 1ps
// The front writes each job it makes into the job queue; the back end then loads its output
// register from the queue head, from which the first result word of that job is offered.
// Throughput: one event per cycle in while the queue is not full; the back end sends one word
// per cycle while not stalled. An init job yields 14 words, a frame 6, a done job 2, others 1.
// The 4-entry job queue sets how far the front runs ahead of the back end.
// Reset (async, low) clears protocol state and loads config defaults; no clearing pass.
module sd_card_init_and_block_read_top #(
  parameter int unsigned BlockWords = sdc_pkg::BlockWordsDef,  // 16..1024
  parameter int unsigned QueueDepth = sdc_pkg::QueueDepthDef   // power of two
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // event channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] block_number_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] rx_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_res_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] out_word_o,
  output logic [7:0]  clock_divisor_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import sdc_pkg::*;

  cfg_t cfg_q;
  logic take;
  logic push, full, job_valid, pop;
  job_t job_in, job_head;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks  <= 24'd2000000;
      cfg_q.voltage_window <= 24'h300000;
      cfg_q.init_clock_div <= 8'd250;
      cfg_q.run_clock_div  <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgTimeout: cfg_q.timeout_ticks  <= cfg_data_i;
        CfgVoltage: cfg_q.voltage_window <= cfg_data_i;
        CfgInitDiv: cfg_q.init_clock_div <= cfg_data_i[7:0];
        default:    cfg_q.run_clock_div  <= cfg_data_i[7:0];
      endcase
    end
  end

  // front stalls only when the job queue is full
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  sdc_front #(.BlockWords(BlockWords)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .take_i         (take),
    .kind_i         (kind_i),
    .block_number_i (block_number_i),
    .rx_byte_i      (rx_byte_i),
    .rx_word_i      (rx_word_i),
    .push_o         (push),
    .job_o          (job_in)
  );

  sdc_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (job_valid),
    .data_o  (job_head)
  );

  sdc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_res_o      (kind_res_o),
    .out_byte_o      (out_byte_o),
    .out_word_o      (out_word_o),
    .clock_divisor_o (clock_divisor_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

[verif/sd_card_init_and_block_read_top_test.sv]
// Testbench for the SD card init and single-block read controller: queued driver, scoreboard.
`timescale 1ns / 1ps
module sd_card_init_and_block_read_top_test;
  import sdc_pkg::*;

  localparam int unsigned BlkWords = 128;
  localparam int unsigned IdleLimit = 1000;

  // controller phases, mirrored in the predictor
  typedef enum logic [4:0] {
    PhIdle, PhCmd8, PhApp, PhOpCond, PhCid, PhRca, PhSelect, PhAppW, PhWidth, PhRead
  } phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] blk;
    logic [7:0]  rxb;
    logic [31:0] rxw;
  } event_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_v;
    logic [31:0] word_v;
    logic [7:0]  div;
    logic [1:0]  status;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic [31:0] block_number_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [31:0] rx_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [1:0]  kind_res_o;
  logic [7:0]  out_byte_o;
  logic [31:0] out_word_o;
  logic [7:0]  clock_divisor_o;
  logic [1:0]  status_o;
  logic        last_o;

  sd_card_init_and_block_read_top i_dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [23:0] m_timeout, m_volt;
  logic [7:0]  m_idiv, m_rdiv;
  phase_e      m_phase;
  int unsigned m_rcnt, m_wcnt, m_wait;
  logic        m_v2, m_hc;
  logic [15:0] m_rca;
  logic [7:0]  m_hold [4];

  event_t  pending_events[$];
  result_t expected_results[$];
  int unsigned errors = 0, n_words = 0, n_checked = 0, n_finish = 0, n_sent = 0;
  int unsigned idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          drain_done = 1'b0;

  task automatic push_res(logic [1:0] k, logic [7:0] b, logic [31:0] w,
                          logic [7:0] d, logic [1:0] s);
    result_t r;
    r = '{kind: k, byte_v: b, word_v: w, div: d, status: s, last: 1'b0};
    expected_results.push_back(r);
  endtask

  task automatic push_frame(logic [5:0] cmd, logic [31:0] arg);
    logic [7:0] f [6];
    logic [6:0] crc;
    logic [7:0] d;
    crc = '0;
    f[0] = {2'b01, cmd};
    f[1] = arg[31:24];
    f[2] = arg[23:16];
    f[3] = arg[15:8];
    f[4] = arg[7:0];
    for (int a = 0; a < 5; a++) begin
      d = f[a];
      for (int i = 0; i < 8; i++) begin
        if (d[7] ^ crc[6]) crc = {crc[5:0], 1'b0} ^ 7'h09;
        else crc = {crc[5:0], 1'b0};
        d = d << 1;
      end
    end
    f[5] = {crc, 1'b1};
    for (int i = 0; i < 6; i++) push_res(ResByte, f[i], '0, '0, StOk);
  endtask

  function automatic logic [31:0] cmd8_arg();
    return ((m_volt & 24'hff8000) != 24'd0) ? 32'h1aa : 32'haa;
  endfunction

  task automatic end_op(logic [1:0] st);
    push_res(ResFinish, '0, '0, '0, st);
    m_phase = PhIdle;
    m_rcnt = 0;
    m_wcnt = 0;
    m_wait = 0;
  endtask

  task automatic issue(logic [5:0] cmd, logic [31:0] arg, phase_e nxt);
    push_frame(cmd, arg);
    m_phase = nxt;
    m_rcnt = 0;
    m_wait = 0;
  endtask

  task automatic reply_complete();
    case (m_phase)
      PhCmd8: begin
        if ({16'd0, m_hold[2], m_hold[3]} != cmd8_arg()) end_op(StMismatch);
        else begin
          m_v2 = 1'b1;
          issue(CmdAppCmd, '0, PhApp);
        end
      end
      PhApp: issue(CmdOpCond, {1'b0, m_v2, 6'b0, m_volt}, PhOpCond);
      PhOpCond: begin
        if (m_hold[0][7]) begin
          m_hc = m_hold[0][6];
          issue(CmdAllCid, '0, PhCid);
        end else issue(CmdAppCmd, '0, PhApp);
      end
      PhCid: issue(CmdSendRca, '0, PhRca);
      PhRca: begin
        m_rca = {m_hold[0], m_hold[1]};
        issue(CmdSelect, {m_rca, 16'h0}, PhSelect);
      end
      PhSelect: issue(CmdAppCmd, {m_rca, 16'h0}, PhAppW);
      PhAppW: issue(CmdBusWidth, 32'd2, PhWidth);
      default: begin
        push_res(ResDiv, '0, '0, m_rdiv, StOk);
        end_op(StOk);
      end
    endcase
  endtask

  // expected results of one accepted word
  task automatic predict_event(event_t e);
    int unsigned n0, need;
    n0 = expected_results.size();
    case (e.kind)
      KindInit, KindRead: begin
        if (m_phase != PhIdle) push_res(ResFinish, '0, '0, '0, StBusy);
        else if (e.kind == KindInit) begin
          m_v2 = 1'b0;
          push_res(ResDiv, '0, '0, m_idiv, StOk);
          push_frame(CmdGoIdle, '0);
          push_res(ResByte, DummyByte, '0, '0, StOk);
          issue(CmdIfCond, cmd8_arg(), PhCmd8);
        end else begin
          issue(CmdReadBlk, m_hc ? e.blk : e.blk * 32'd512, PhRead);
          m_wcnt = 0;
        end
      end
      KindReply: begin
        if (m_phase == PhRead) begin
          if (m_rcnt < 6) begin
            m_rcnt++;
            m_wait = 0;
          end
        end else if (m_phase != PhIdle) begin
          need = (m_phase == PhCid) ? 17 : 6;
          if (m_rcnt >= 1 && m_rcnt <= 4) m_hold[m_rcnt - 1] = e.rxb;
          m_rcnt++;
          m_wait = 0;
          if (m_rcnt >= need) begin
            m_rcnt = 0;
            reply_complete();
          end
        end
      end
      KindData: begin
        if (m_phase == PhRead) begin
          m_wait = 0;
          m_wcnt++;
          if (m_wcnt <= BlkWords) push_res(ResWord, '0, e.rxw, '0, StOk);
          else if (m_wcnt >= BlkWords + 2) end_op(StOk);
        end
      end
      KindTick: begin
        if (m_phase != PhIdle) begin
          m_wait++;
          if (m_wait >= ((m_timeout == 24'd0) ? 1 : m_timeout)) begin
            m_wait = 0;
            m_rcnt = 0;
            if (m_phase == PhCmd8) begin
              m_v2 = 1'b0;
              issue(CmdAppCmd, '0, PhApp);
            end else end_op(StTimeout);
          end
        end
      end
      default: ;
    endcase
    if (expected_results.size() > n0)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  // handshake state captured at the rising edge
  logic in_stall_o_q = 1'b1;
  always @(posedge clk_i) begin
    event_t e;
    in_stall_o_q <= in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      e = '{kind: kind_i, blk: block_number_i, rxb: rx_byte_i, rxw: rx_word_i};
      n_sent++;
      predict_event(e);
    end
  end

  // driver: one word per handshake, random gap after each
  int unsigned gap = 0;
  bit          pause_sender = 1'b0;
  always @(negedge clk_i) begin
    event_t e;
    if (rst_ni) begin
      // a stalled word stays put; otherwise offer the next one or idle
      if (!(in_valid_i && in_stall_o_q)) begin
        if (gap != 0) begin
          gap <= gap - 1;
          in_valid_i <= 1'b0;
        end else if (!pause_sender && pending_events.size() != 0) begin
          e = pending_events.pop_front();
          kind_i <= e.kind;
          block_number_i <= e.blk;
          rx_byte_i <= e.rxb;
          rx_word_i <= e.rxw;
          in_valid_i <= 1'b1;
          gap <= $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        hold_left <= 400;
        long_hold <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(0, 7);
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind: kind_res_o, byte_v: out_byte_o, word_v: out_word_o,
              div: clock_divisor_o, status: status_o, last: last_o};
      n_checked++;
      if (got.kind == ResWord) n_words++;
      if (got.kind == ResFinish) n_finish++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch, expected %p actual %p", $time, exp_r, got);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni ||
        hold_left != 0 || drain_done)
      idle_cycles <= 0;
    else if (pending_events.size() != 0 || expected_results.size() != 0 || in_valid_i) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] r8();
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] r32();
    return $urandom;
  endfunction

  function automatic event_t mk(logic [2:0] k, logic [31:0] b, logic [7:0] rb,
                                logic [31:0] rw);
    return '{kind: k, blk: b, rxb: rb, rxw: rw};
  endfunction

  task automatic add(logic [2:0] k, logic [31:0] b, logic [7:0] rb, logic [31:0] rw);
    pending_events.push_back(mk(k, b, rb, rw));
  endtask

  // one six-byte reply, bytes 1..4 given
  task automatic add_reply(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3, logic [7:0] b4);
    add(KindReply, r32(), r8(), r32());
    add(KindReply, r32(), b1, r32());
    add(KindReply, r32(), b2, r32());
    add(KindReply, r32(), b3, r32());
    add(KindReply, r32(), b4, r32());
    add(KindReply, r32(), r8(), r32());
  endtask

  // full init of a version-2 card with random card content
  task automatic add_init(int unsigned busy_loops, logic [23:0] volt);
    logic [15:0] echo;
    echo = ((volt & 24'hff8000) != 24'd0) ? 16'h1aa : 16'haa;
    add(KindInit, r32(), r8(), r32());
    add_reply(r8(), r8(), echo[15:8], echo[7:0]);
    for (int unsigned l = 0; l <= busy_loops; l++) begin
      add_reply(r8(), r8(), r8(), r8());
      if (l == busy_loops) add_reply(r8() | 8'h80, r8(), r8(), r8());
      else add_reply(r8() & 8'h7f, r8(), r8(), r8());
    end
    for (int i = 0; i < 17; i++) add(KindReply, r32(), r8(), r32());
    for (int i = 0; i < 4; i++) add_reply(r8(), r8(), r8(), r8());
  endtask

  task automatic add_read(logic [31:0] blk, bit short_reply);
    add(KindRead, blk, r8(), r32());
    for (int i = 0; i < (short_reply ? 3 : 7); i++)
      add(KindReply, r32(), r8(), r32());
    for (int i = 0; i < BlkWords + 2; i++) begin
      if ($urandom_range(0, 31) == 0) add(KindTick, r32(), r8(), r32());
      add(KindData, r32(), r8(), r32());
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTimeout: m_timeout = val;
      CfgVoltage: m_volt = val;
      CfgInitDiv: m_idiv = val[7:0];
      default: m_rdiv = val[7:0];
    endcase
  endtask

  initial begin
    m_timeout = 24'd2000000;
    m_volt = 24'h300000;
    m_idiv = 8'd250;
    m_rdiv = 8'd3;
    m_phase = PhIdle;
    m_rcnt = 0;
    m_wcnt = 0;
    m_wait = 0;
    m_v2 = 1'b0;
    m_hc = 1'b0;
    m_rca = '0;
    for (int i = 0; i < 4; i++) m_hold[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults, stray words, extremes of registers
    add(KindTick, '0, '0, '0);
    add(KindReply, '1, '1, '1);
    add(KindData, '0, '0, '1);
    add(3'd7, '1, '1, '1);
    add(KindRead, 32'hffffffff, '0, '0);     // read before init, address wraps
    add(KindInit, '0, '0, '0);               // refused busy
    add(KindData, '0, '0, 32'hffffffff);
    add(KindTick, '0, '0, '0);
    wait_drained();
    write_cfg(CfgTimeout, 24'd2);
    add(KindTick, '0, '0, '0);               // timeout in read
    add(KindTick, '0, '0, '0);
    add(KindInit, '0, '0, '0);
    add_reply(8'h00, 8'h00, 8'h01, 8'h55);   // echo mismatch
    wait_drained();
    write_cfg(CfgTimeout, 24'd0);            // zero acts as one
    write_cfg(CfgVoltage, 24'hffffff);
    write_cfg(CfgInitDiv, 24'd0);
    write_cfg(CfgRunDiv, 24'd255);
    add(KindInit, r32(), r8(), r32());
    add(KindRead, r32(), r8(), r32());       // refused busy
    add(KindTick, r32(), r8(), r32());       // CMD8 timeout, version-1 card
    add(KindTick, r32(), r8(), r32());       // timeout waiting for CMD55 reply
    wait_drained();
    write_cfg(CfgTimeout, 24'hffffff);
    write_cfg(CfgVoltage, 24'h007fff);
    write_cfg(CfgInitDiv, 24'd255);
    write_cfg(CfgRunDiv, 24'd0);
    add_init(1, 24'h007fff);
    add_read(r32(), 1'b1);
    // receiver holds off during the block while the sender keeps offering
    while (pending_events.size() > 100) @(posedge clk_i);
    long_hold = 1'b1;
    // sender pauses until every expected result is back
    while (pending_events.size() > 40) @(posedge clk_i);
    pause_sender = 1'b1;
    while (in_valid_i || expected_results.size() != 0) @(posedge clk_i);
    pause_sender = 1'b0;
    wait_drained();

    drain_done = 1'b1;
    $display("Sent %0d words; checked %0d results, %0d data words, %0d finish words.",
             n_sent, n_checked, n_words, n_finish);
    $display("Init, CMD8 timeout, echo mismatch, reads, timeouts, busy refusal, stalls.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
